// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL of the dirty tile box unit.
// Synthesis builds define SYNTHESIS, which turns every macro into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FDTB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FDTB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FDTB_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FDTB_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/fdtb_pkg.sv =====
// Package of the dirty tile box unit: panel geometry, word types and the
// event passed to the box tracker. Depends on nothing.
`timescale 1ns / 1ps
package fdtb_pkg;
    localparam int TILES_ACROSS = 38;
    localparam int TILES_DOWN = 50;
    localparam int TILE_COUNT = TILES_ACROSS * TILES_DOWN;
    localparam int IDX_W = $clog2(TILE_COUNT);
    localparam int POS_W = 6;
    localparam int TILE_W = 64;

    typedef struct packed {
        logic [POS_W-1:0] tile_col;
        logic [POS_W-1:0] tile_row;
        logic [TILE_W-1:0] tile_bits;
        logic frame_end;
    } in_word_t;

    typedef struct packed {
        logic full_refresh;
        logic changed;
        logic [POS_W-1:0] first_col;
        logic [POS_W-1:0] last_col;
        logic [POS_W-1:0] first_row;
        logic [POS_W-1:0] last_row;
    } out_word_t;

    typedef struct packed {
        logic fire;
        logic last;
        logic in_range;
        logic differs;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } box_event_t;
endpackage

// ===== src/frame_dirty_tile_box_unit.sv =====
// Top level of the dirty tile box unit: address stage, shadow RAM, forwarding,
// compare stage and result register. Depends on fdtb_pkg, fdtb_ram, fdtb_box, assert_macros.svh.
//
// The unit takes one tile word per clock on the in channel (valid/ready) and
// gives one result word on the out channel (valid/ready) for every tile word
// whose frame_end bit is set; other tile words give no result.
// A tile word is accepted when in_valid and in_ready are high at a clock edge.
// Its shadow tile is read from the RAM at that edge, compared in the next cycle,
// and the new tile is written back at the edge at which the compare stage fires.
// A tile that hits the entry written by the word just before it takes the
// forwarded data. A result is in the output register at the edge at which its
// frame-end word leaves the compare stage. With out_ready held high the unit
// takes one word every cycle. When the receiver stalls, the result waits in the
// output register; words keep flowing until a second frame end reaches the
// compare stage, which then holds and drops in_ready until the result is taken.
// Reset clears the trackers and the shadow valid flag, so the first frame
// after reset reports a full refresh. The shadow RAM is not cleared; it is
// filled by that first frame.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module frame_dirty_tile_box_unit
    import fdtb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_word
);
    logic              accept;
    logic              in_range;
    logic [IDX_W-1:0]  in_idx;
    logic              s1_valid_reg;
    in_word_t          s1_word_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s1_in_range_reg;
    logic              s1_fire;
    logic              s1_write;
    logic              fwd_hit_reg;
    logic [TILE_W-1:0] fwd_bits_reg;
    logic [TILE_W-1:0] ram_rd_data;
    logic [TILE_W-1:0] old_bits;
    logic              out_valid_reg;
    out_word_t         out_word_reg;
    box_event_t        ev;
    out_word_t         result;

    assign in_range = (int'(in_word.tile_col) < TILES_ACROSS) &&
                      (int'(in_word.tile_row) < TILES_DOWN);
    assign in_idx = IDX_W'(int'(in_word.tile_row) * TILES_ACROSS + int'(in_word.tile_col));

    assign s1_fire = s1_valid_reg && (!s1_word_reg.frame_end || !out_valid_reg || out_ready);
    assign s1_write = s1_fire && s1_in_range_reg;
    assign in_ready = !s1_valid_reg || s1_fire;
    assign accept = in_valid && in_ready;

    fdtb_ram #(
        .WIDTH (TILE_W),
        .DEPTH (TILE_COUNT)
    ) u_shadow (
        .clk     (clk),
        .wr_en   (s1_write),
        .wr_addr (s1_idx_reg),
        .wr_data (s1_word_reg.tile_bits),
        .rd_en   (accept),
        .rd_addr (in_idx),
        .rd_data (ram_rd_data)
    );

    assign old_bits = fwd_hit_reg ? fwd_bits_reg : ram_rd_data;

    always_comb
    begin
        ev.fire = s1_fire;
        ev.last = s1_word_reg.frame_end;
        ev.in_range = s1_in_range_reg;
        ev.differs = old_bits != s1_word_reg.tile_bits;
        ev.col = s1_word_reg.tile_col;
        ev.row = s1_word_reg.tile_row;
    end

    fdtb_box u_box (
        .clk    (clk),
        .rst_n  (rst_n),
        .ev     (ev),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire && s1_word_reg.frame_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg <= in_word;
            s1_idx_reg <= in_idx;
            s1_in_range_reg <= in_range;
            fwd_hit_reg <= s1_write && (s1_idx_reg == in_idx);
            fwd_bits_reg <= s1_word_reg.tile_bits;
        end
        if (s1_fire && s1_word_reg.frame_end)
        begin
            out_word_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word = out_word_reg;

    `FDTB_ASSERT_IMP(a_stall_only_on_end, clk, rst_n, s1_valid_reg && !s1_fire,
        s1_word_reg.frame_end && out_valid_reg && !out_ready)
    `FDTB_ASSERT_NXT(a_result_loaded, clk, rst_n, s1_fire && s1_word_reg.frame_end,
        out_valid_reg)
    `FDTB_ASSERT_IMP(a_no_write_out_of_range, clk, rst_n, s1_write,
        s1_in_range_reg && s1_valid_reg)
endmodule

// ===== src/fdtb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module fdtb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== src/fdtb_box.sv =====
// Changed-box tracker: shadow valid flag, min and max column and row, and
// the end-of-frame result. Depends on fdtb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fdtb_box
    import fdtb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  box_event_t ev,
    output out_word_t  result
);
    logic             shadow_valid_reg;
    logic             any_change_reg, any_change_next;
    logic [POS_W-1:0] min_col_reg, min_col_next;
    logic [POS_W-1:0] max_col_reg, max_col_next;
    logic [POS_W-1:0] min_row_reg, min_row_next;
    logic [POS_W-1:0] max_row_reg, max_row_next;
    logic             hit;

    assign hit = shadow_valid_reg && ev.in_range && ev.differs;

    always_comb
    begin
        any_change_next = any_change_reg;
        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        if (hit)
        begin
            any_change_next = 1'b1;
            if (!any_change_reg || ev.col < min_col_reg) min_col_next = ev.col;
            if (!any_change_reg || ev.col > max_col_reg) max_col_next = ev.col;
            if (!any_change_reg || ev.row < min_row_reg) min_row_next = ev.row;
            if (!any_change_reg || ev.row > max_row_reg) max_row_next = ev.row;
        end
    end

    always_comb
    begin
        result = '0;
        if (!shadow_valid_reg)
        begin
            result.full_refresh = 1'b1;
            result.changed = 1'b1;
            result.last_col = POS_W'(TILES_ACROSS - 1);
            result.last_row = POS_W'(TILES_DOWN - 1);
        end
        else if (any_change_next)
        begin
            result.changed = 1'b1;
            result.first_col = min_col_next;
            result.last_col = max_col_next;
            result.first_row = min_row_next;
            result.last_row = max_row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_valid_reg <= 1'b0;
            any_change_reg <= 1'b0;
            min_col_reg <= POS_W'(TILES_ACROSS);
            max_col_reg <= '0;
            min_row_reg <= POS_W'(TILES_DOWN);
            max_row_reg <= '0;
        end
        else if (ev.fire)
        begin
            if (ev.last)
            begin
                shadow_valid_reg <= 1'b1;
                any_change_reg <= 1'b0;
                min_col_reg <= POS_W'(TILES_ACROSS);
                max_col_reg <= '0;
                min_row_reg <= POS_W'(TILES_DOWN);
                max_row_reg <= '0;
            end
            else
            begin
                any_change_reg <= any_change_next;
                min_col_reg <= min_col_next;
                max_col_reg <= max_col_next;
                min_row_reg <= min_row_next;
                max_row_reg <= max_row_next;
            end
        end
    end

    `FDTB_ASSERT_IMP(a_box_ordered, clk, rst_n, any_change_reg,
        min_col_reg <= max_col_reg && min_row_reg <= max_row_reg)
    `FDTB_ASSERT_IMP(a_change_needs_shadow, clk, rst_n, any_change_reg, shadow_valid_reg)
    `FDTB_ASSERT_NXT(a_frame_sets_shadow, clk, rst_n, ev.fire && ev.last,
        shadow_valid_reg && !any_change_reg)
endmodule
